// ===== hw/rtl/dfu_pkg.sv =====
// Shared types, codes and helpers for the DFU controller.
`timescale 1ns / 1ps
package dfu_pkg;

    localparam int BUFFER_BYTES_DEF = 128;

    // item classes after the front end
    localparam logic [1:0] K_REQ  = 2'd0;
    localparam logic [1:0] K_DATA = 2'd1;
    localparam logic [1:0] K_CMP  = 2'd2;

    // class request codes
    localparam logic [2:0] RQ_DETACH    = 3'd0;
    localparam logic [2:0] RQ_DNLOAD    = 3'd1;
    localparam logic [2:0] RQ_UPLOAD    = 3'd2;
    localparam logic [2:0] RQ_GETSTATUS = 3'd3;
    localparam logic [2:0] RQ_CLRSTATUS = 3'd4;
    localparam logic [2:0] RQ_GETSTATE  = 3'd5;
    localparam logic [2:0] RQ_ABORT     = 3'd6;

    // DFU states
    localparam logic [3:0] ST_IDLE          = 4'd2;
    localparam logic [3:0] ST_DNLOAD_SYNC   = 4'd3;
    localparam logic [3:0] ST_DNBUSY        = 4'd4;
    localparam logic [3:0] ST_DNLOAD_IDLE   = 4'd5;
    localparam logic [3:0] ST_MANIFEST_SYNC = 4'd6;
    localparam logic [3:0] ST_MANIFEST      = 4'd7;
    localparam logic [3:0] ST_UPLOAD_IDLE   = 4'd9;
    localparam logic [3:0] ST_ERROR         = 4'd10;

    // memory operations
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_ERASE = 3'd1;
    localparam logic [2:0] OP_PROG  = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_LIST  = 3'd4;

    localparam logic [7:0]  CMD_SET_ADDRESS = 8'h21;
    localparam logic [7:0]  CMD_ERASE_PAGE  = 8'h41;
    localparam logic [6:0]  REQ_TYPE_CLASS  = 7'h21;
    localparam logic [23:0] BUSY_POLL_MS    = 24'd100;

    // config register indexes
    localparam logic [1:0] CFG_LOADER_START = 2'd0;
    localparam logic [1:0] CFG_APP_START    = 2'd1;
    localparam logic [1:0] CFG_APP_LAST     = 2'd2;

    localparam logic [31:0] LOADER_START_RST = 32'h0800_0000;
    localparam logic [31:0] APP_START_RST    = 32'h0800_4000;
    localparam logic [31:0] APP_LAST_RST     = 32'h0801_FFFF;

    typedef struct packed {
        logic [1:0]  cls;
        logic        supported;
        logic [2:0]  code;
        logic [15:0] block_value;
        logic [15:0] request_length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic        start_app;
        logic [15:0] mem_data;
        logic [31:0] mem_addr;
        logic [2:0]  mem_op;
        logic [3:0]  dfu_state_out;
        logic [23:0] poll_timeout;
        logic [3:0]  status_code;
        logic [7:0]  reply_length;
        logic        handled;
    } result_t;

    // span [base, base+len) inside [low, last], no wrap
    function automatic logic span_ok(input logic [31:0] base, input logic [31:0] low,
                                     input logic [31:0] last, input logic [7:0] len);
        logic [32:0] hi_end;
        logic [32:0] lim;
        hi_end = {1'b0, base} + {25'd0, len};
        lim    = {1'b0, last} + 33'd1;
        return (base >= low) && (hi_end <= lim);
    endfunction

endpackage

// ===== hw/rtl/dfu_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module dfu_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [55:0]     s_tdata,
    input  logic [1:0]      s_tuser,
    output logic            q_valid,
    output dfu_pkg::item_t  q_item,
    input  logic            q_pop
);

    dfu_pkg::item_t fifo_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    dfu_pkg::item_t item;
    logic           push;

    always_comb begin
        item.cls            = s_tuser;
        item.supported      = (s_tdata[6:0] == dfu_pkg::REQ_TYPE_CLASS) &&
                              (s_tdata[15:8] <= 8'd6);
        item.code           = s_tdata[10:8];
        item.block_value    = s_tdata[31:16];
        item.request_length = s_tdata[47:32];
        item.data_byte      = s_tdata[55:48];
    end

    assign s_tready = (count_reg != 2'd2);
    // unused kind is taken and dropped here
    assign push     = s_tvalid && s_tready && (s_tuser != 2'd3);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop && q_valid) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
        end
    end

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2) else $error("queue overflow");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2) |-> !push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0) |=> (count_reg <= 2'd1)) else $error("pop from empty queue");

endmodule

// ===== hw/rtl/dfu_back.sv =====
// Back end: DFU state, block buffer, address checks and result register.
`timescale 1ns / 1ps
module dfu_back #(
    parameter int BUFFER_BYTES = dfu_pkg::BUFFER_BYTES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  dfu_pkg::item_t  q_item,
    output logic            q_pop,
    input  logic [31:0]     loader_start,
    input  logic [31:0]     app_start,
    input  logic [31:0]     app_last,
    output logic            out_valid,
    output dfu_pkg::result_t out_res,
    output logic            out_last,
    input  logic            out_ready
);

    localparam int HALF = (BUFFER_BYTES + 1) / 2;
    localparam int HW_W = (HALF > 1) ? $clog2(HALF) : 1;
    localparam logic [7:0]  BB8  = 8'(BUFFER_BYTES);
    localparam logic [31:0] BB32 = 32'(BUFFER_BYTES);

    localparam logic [2:0] B_IDLE   = 3'd0;
    localparam logic [2:0] B_ADDR   = 3'd1;
    localparam logic [2:0] B_EXEC   = 3'd2;
    localparam logic [2:0] B_PRG_RD = 3'd3;
    localparam logic [2:0] B_PRG_OUT = 3'd4;

    logic [2:0]  bst_reg, bst_next;
    logic [3:0]  dfu_state_reg;
    logic [7:0]  buf_len_reg;
    logic [7:0]  fill_reg;
    logic [15:0] block_reg;
    logic [31:0] addr_ptr_reg;
    logic [31:0] base_reg;
    logic [7:0]  idx_reg;
    logic [7:0]  head_reg [5];
    dfu_pkg::item_t cur_reg;

    logic [7:0] mem_e [HALF];
    logic [7:0] mem_o [HALF];
    logic [7:0] rd_e_reg;
    logic [7:0] rd_o_reg;

    logic             out_valid_reg;
    logic             out_last_reg;
    dfu_pkg::result_t out_res_reg;
    logic             can_load;

    logic             data_wr;
    logic [31:0]      buf_word;
    logic [15:0]      blk_sel;
    logic [31:0]      blk_off;

    dfu_pkg::result_t ex_res;
    logic [3:0]       ex_state;
    logic             ex_emit;
    logic             ex_prg;
    logic             ex_set_addr;
    logic [7:0]       idx_nx;

    dfu_pkg::result_t prg_res;
    logic             prg_last;
    logic             load_ex;
    logic             load_prg;

    assign can_load  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_last  = out_last_reg;
    assign q_pop     = (bst_reg == B_IDLE) && q_valid;
    assign data_wr   = q_pop && (q_item.cls == dfu_pkg::K_DATA) && (fill_reg < buf_len_reg);
    assign buf_word  = {head_reg[4], head_reg[3], head_reg[2], head_reg[1]};
    assign blk_sel   = (cur_reg.cls == dfu_pkg::K_REQ) ? cur_reg.block_value : block_reg;
    assign blk_off   = ({16'd0, blk_sel} - 32'd2) * BB32;
    assign idx_nx    = idx_reg + 8'd2;
    assign prg_last  = ({1'b0, idx_nx} >= {1'b0, buf_len_reg});
    assign load_ex   = (bst_reg == B_EXEC) && can_load && ex_emit;
    assign load_prg  = (bst_reg == B_PRG_OUT) && can_load;

    // buffer, split into even and odd byte lanes so a half-word reads in one go
    always_ff @(posedge aclk) begin
        if (data_wr && !fill_reg[0]) begin
            mem_e[fill_reg[HW_W:1]] <= q_item.data_byte;
        end
        if (data_wr && fill_reg[0]) begin
            mem_o[fill_reg[HW_W:1]] <= q_item.data_byte;
        end
        if (bst_reg == B_PRG_RD) begin
            rd_e_reg <= mem_e[idx_reg[HW_W:1]];
            rd_o_reg <= mem_o[idx_reg[HW_W:1]];
        end
    end

    // copy of the first bytes for the block-zero commands
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 5; k++) begin
                head_reg[k] <= 8'd0;
            end
        end else if (data_wr && fill_reg < 8'd5) begin
            head_reg[fill_reg[2:0]] <= q_item.data_byte;
        end
    end

    always_comb begin
        ex_res             = '0;
        ex_state           = dfu_state_reg;
        ex_emit            = 1'b1;
        ex_prg             = 1'b0;
        ex_set_addr        = 1'b0;
        if (cur_reg.cls == dfu_pkg::K_REQ) begin
            if (cur_reg.supported) begin
                ex_res.handled = 1'b1;
                case (cur_reg.code)
                    dfu_pkg::RQ_DETACH: ex_state = dfu_pkg::ST_MANIFEST_SYNC;
                    dfu_pkg::RQ_DNLOAD: begin
                        ex_state = (cur_reg.request_length == 16'd0) ?
                                   dfu_pkg::ST_MANIFEST_SYNC : dfu_pkg::ST_DNLOAD_SYNC;
                    end
                    dfu_pkg::RQ_UPLOAD: begin
                        ex_state = dfu_pkg::ST_UPLOAD_IDLE;
                        if (cur_reg.block_value == 16'd0) begin
                            ex_res.mem_op       = dfu_pkg::OP_LIST;
                            ex_res.reply_length = 8'd3;
                        end else if (dfu_pkg::span_ok(base_reg, loader_start,
                                                      app_last, BB8)) begin
                            ex_res.mem_op       = dfu_pkg::OP_READ;
                            ex_res.mem_addr     = base_reg;
                            ex_res.reply_length = BB8;
                        end else begin
                            ex_state = dfu_pkg::ST_ERROR;
                        end
                    end
                    dfu_pkg::RQ_GETSTATUS: begin
                        if (dfu_state_reg == dfu_pkg::ST_DNLOAD_SYNC) begin
                            ex_state            = dfu_pkg::ST_DNBUSY;
                            ex_res.poll_timeout = dfu_pkg::BUSY_POLL_MS;
                        end else if (dfu_state_reg == dfu_pkg::ST_MANIFEST_SYNC) begin
                            ex_state = dfu_pkg::ST_MANIFEST;
                        end
                        ex_res.reply_length = 8'd6;
                    end
                    dfu_pkg::RQ_CLRSTATUS: begin
                        if (dfu_state_reg == dfu_pkg::ST_ERROR) begin
                            ex_state = dfu_pkg::ST_IDLE;
                        end
                    end
                    dfu_pkg::RQ_GETSTATE: ex_res.reply_length = 8'd1;
                    default: ex_state = dfu_pkg::ST_IDLE;
                endcase
            end
        end else begin
            if (dfu_state_reg == dfu_pkg::ST_DNBUSY) begin
                ex_state = dfu_pkg::ST_DNLOAD_IDLE;
                if (block_reg == 16'd0) begin
                    if (head_reg[0] == dfu_pkg::CMD_ERASE_PAGE) begin
                        if (dfu_pkg::span_ok(base_reg, app_start, app_last, BB8)) begin
                            ex_res.mem_op   = dfu_pkg::OP_ERASE;
                            ex_res.mem_addr = base_reg;
                        end
                    end else if (head_reg[0] == dfu_pkg::CMD_SET_ADDRESS) begin
                        ex_set_addr = 1'b1;
                    end
                end else if (buf_len_reg != 8'd0 &&
                             dfu_pkg::span_ok(base_reg, app_start, app_last, buf_len_reg)) begin
                    ex_prg  = 1'b1;
                    ex_emit = 1'b0;
                end
            end else if (dfu_state_reg == dfu_pkg::ST_MANIFEST) begin
                ex_state         = dfu_pkg::ST_IDLE;
                ex_res.start_app = 1'b1;
            end
        end
        ex_res.dfu_state_out = ex_state;
    end

    // one program half-word result, odd tail padded with 0xFF
    always_comb begin
        prg_res               = '0;
        prg_res.mem_op        = dfu_pkg::OP_PROG;
        prg_res.mem_addr      = base_reg + {24'd0, idx_reg};
        prg_res.mem_data      = {((idx_reg + 8'd1) < buf_len_reg) ? rd_o_reg : 8'hFF,
                                 rd_e_reg};
        prg_res.dfu_state_out = dfu_state_reg;
    end

    always_comb begin
        bst_next = bst_reg;
        case (bst_reg)
            B_IDLE: begin
                if (q_valid && q_item.cls != dfu_pkg::K_DATA) begin
                    bst_next = B_ADDR;
                end
            end
            B_ADDR: bst_next = B_EXEC;
            B_EXEC: begin
                if (can_load) begin
                    bst_next = ex_prg ? B_PRG_RD : B_IDLE;
                end
            end
            B_PRG_RD: bst_next = B_PRG_OUT;
            B_PRG_OUT: begin
                if (can_load) begin
                    bst_next = prg_last ? B_IDLE : B_PRG_RD;
                end
            end
            default: bst_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_item;
        end
        if (bst_reg == B_ADDR) begin
            base_reg <= (cur_reg.cls == dfu_pkg::K_CMP && block_reg == 16'd0) ?
                        buf_word : addr_ptr_reg + blk_off;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bst_reg       <= B_IDLE;
            dfu_state_reg <= dfu_pkg::ST_IDLE;
            buf_len_reg   <= 8'd0;
            fill_reg      <= 8'd0;
            block_reg     <= 16'd0;
            addr_ptr_reg  <= 32'd0;
            idx_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_res_reg   <= '0;
        end else begin
            bst_reg <= bst_next;
            if (load_ex || load_prg) begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= load_ex ? 1'b1 : prg_last;
                out_res_reg   <= load_ex ? ex_res : prg_res;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (data_wr) begin
                fill_reg <= fill_reg + 8'd1;
            end
            if (bst_reg == B_EXEC && can_load) begin
                dfu_state_reg <= ex_state;
                if (ex_set_addr) begin
                    addr_ptr_reg <= buf_word;
                end
                if (cur_reg.cls == dfu_pkg::K_REQ && cur_reg.supported &&
                    cur_reg.code == dfu_pkg::RQ_DNLOAD && cur_reg.request_length != 16'd0) begin
                    block_reg   <= cur_reg.block_value;
                    buf_len_reg <= (cur_reg.request_length > {8'd0, BB8}) ?
                                   BB8 : cur_reg.request_length[7:0];
                    fill_reg    <= 8'd0;
                end
                idx_reg <= 8'd0;
            end
            if (load_prg) begin
                idx_reg <= idx_nx;
            end
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= buf_len_reg) else $error("fill index past buffer length");
    a_prg_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (bst_reg == B_PRG_OUT) |-> (dfu_state_reg == dfu_pkg::ST_DNLOAD_IDLE &&
                                    idx_reg < buf_len_reg))
        else $error("program step out of place");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> ($stable(out_res_reg) && out_valid_reg))
        else $error("result overwritten");

endmodule

// ===== hw/rtl/dfu_download_upload_controller.sv =====
// Top level of the DFU download/upload controller.
// Data byte: written into the block buffer when the back end pops it (one queue stage).
// Request: result passes the queue, address and decide steps (decide into output register).
// Completion with programming: each half-word is read, then output; m_tready low stalls it.
// The two-entry queue takes new items while the back end works.
// Reset (aresetn low, synchronous): dfuIDLE, lengths, block and pointer cleared, queue empty.
`timescale 1ns / 1ps
module dfu_download_upload_controller #(
    parameter int BUFFER_BYTES = dfu_pkg::BUFFER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // request_type[7:0], request_code[15:8], block_value[31:16],
    // request_length[47:32], data_byte[55:48]
    input  logic [55:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    // handled[0], reply_length[8:1], status_code[12:9], poll_timeout[36:13],
    // dfu_state_out[40:37], mem_op[43:41], mem_addr[75:44], mem_data[91:76],
    // start_app[92], zero[95:93]
    output logic [95:0] m_tdata,
    output logic        m_tlast
);

    logic             q_valid;
    logic             q_pop;
    dfu_pkg::item_t   q_item;
    dfu_pkg::result_t res;
    logic [31:0]      loader_start_reg;
    logic [31:0]      app_start_reg;
    logic [31:0]      app_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loader_start_reg <= dfu_pkg::LOADER_START_RST;
            app_start_reg    <= dfu_pkg::APP_START_RST;
            app_last_reg     <= dfu_pkg::APP_LAST_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                dfu_pkg::CFG_LOADER_START: loader_start_reg <= cfg_data;
                dfu_pkg::CFG_APP_START:    app_start_reg    <= cfg_data;
                dfu_pkg::CFG_APP_LAST:     app_last_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    dfu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    dfu_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .loader_start (loader_start_reg),
        .app_start    (app_start_reg),
        .app_last     (app_last_reg),
        .out_valid    (m_tvalid),
        .out_res      (res),
        .out_last     (m_tlast),
        .out_ready    (m_tready)
    );

    assign m_tdata = {3'd0, res.start_app, res.mem_data, res.mem_addr, res.mem_op,
                      res.dfu_state_out, res.poll_timeout, res.status_code,
                      res.reply_length, res.handled};

endmodule
